// ----- rtl/core/query_argument_finder_top_defines.svh -----
// assertion macros for the query argument finder
`ifndef QUERY_ARGUMENT_FINDER_TOP_DEFINES_SVH
`define QUERY_ARGUMENT_FINDER_TOP_DEFINES_SVH

// checked on every clock edge out of reset
`define QAF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define QAF_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/qaf_pkg.sv -----
// shared types, constants and helpers for the query argument finder
package qaf_pkg;

  localparam int KEY_MAX_DEF    = 8;
  localparam int MAX_LENGTH_DEF = 65535;
  localparam int IN_TDATA_W     = 8;
  localparam int OUT_TDATA_W    = 40;
  localparam int CFG_DATA_W     = 64;

  localparam logic [7:0] CH_AMP = 8'h26;
  localparam logic [7:0] CH_EQ  = 8'h3D;

  localparam logic REG_KEY_BYTES  = 1'b0;
  localparam logic REG_KEY_LENGTH = 1'b1;

  typedef struct packed {
    logic hit_self;
    logic hit_next;
    logic is_amp;
  } qaf_cell_stat_t;

  typedef struct packed {
    logic follow_hit;
    logic end_hit;
    logic amp_before;
  } qaf_win_t;

  function automatic logic [7:0] qaf_fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/qaf_cell.sv -----
// one window cell: holds a folded byte and compares it against two key bytes
module qaf_cell
  import qaf_pkg::*;
(
  input  logic           clk,
  input  logic           shift_en,
  input  logic [7:0]     byte_in,
  input  logic [7:0]     key_self,
  input  logic [7:0]     key_next,
  input  logic           use_self,
  input  logic           use_next,
  output logic [7:0]     byte_out,
  output qaf_cell_stat_t stat
);

  logic [7:0] byte_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= byte_in;
    end
  end

  assign byte_out      = byte_r;
  assign stat.hit_self = !use_self || (byte_r == key_self);
  assign stat.hit_next = !use_next || (byte_r == key_next);
  assign stat.is_amp   = (byte_r == CH_AMP);

endmodule

// ----- rtl/core/qaf_window.sv -----
// row of byte cells with the name compare reduced over the active cells
module qaf_window
  import qaf_pkg::*;
#(
  parameter int KEY_MAX = KEY_MAX_DEF
) (
  input  logic        clk,
  input  logic        shift_en,
  input  logic [7:0]  byte_in,
  input  logic [63:0] key_bytes,
  input  logic [3:0]  key_len,
  output qaf_win_t    win
);

  localparam int NCELL = KEY_MAX + 1;

  logic [7:0]     kb [8];
  logic [7:0]     chain [NCELL+1];
  qaf_cell_stat_t stat [NCELL];
  logic [NCELL-1:0] self_v;
  logic [NCELL-1:0] next_v;
  logic [NCELL-1:0] amp_v;
  logic [7:0]     byte_f;

  assign byte_f   = qaf_fold(byte_in);
  assign chain[0] = byte_f;

  for (genvar j = 0; j < 8; j++) begin : g_key
    assign kb[j] = qaf_fold(key_bytes[8*j +: 8]);
  end

  for (genvar m = 0; m < NCELL; m++) begin : g_cell
    localparam logic [3:0] M = 4'(m);
    logic [3:0] idx_self;
    logic [3:0] idx_next;

    assign idx_self = key_len - 4'd1 - M;
    assign idx_next = key_len - 4'd2 - M;

    qaf_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .byte_in  (chain[m]),
      .key_self (kb[idx_self[2:0]]),
      .key_next (kb[idx_next[2:0]]),
      .use_self (M < key_len),
      .use_next ((M + 4'd1) < key_len),
      .byte_out (chain[m+1]),
      .stat     (stat[m])
    );

    assign self_v[m] = stat[m].hit_self;
    assign next_v[m] = stat[m].hit_next;
    assign amp_v[m]  = stat[m].is_amp && (M == key_len);
  end

  logic [3:0] idx_top;
  assign idx_top = key_len - 4'd1;

  // name followed by the incoming byte: cells 0..len-1
  assign win.follow_hit = &self_v;
  // name ending at the incoming byte
  assign win.end_hit    = (byte_f == kb[idx_top[2:0]]) && (&next_v);
  // byte just ahead of the name
  assign win.amp_before = |amp_v;

endmodule

// ----- rtl/core/query_argument_finder_top.sv -----
// top level of the query argument finder: control, registers and output stage
//
// channel | dir | handshake            | content
// in_     | in  | in_tvalid/in_tready  | tdata byte, tlast end of string, tuser empty string
// out_    | out | out_tvalid/out_tready| found, has_value, value_offset, value_length
// cfg_    | in  | cfg_valid/cfg_ready  | cfg_index selects key_bytes or key_length
//
// one query byte per clock while in_tready is high; the row of byte cells compares the whole name combinationally
// the result of a string appears on out_ in the cycle after its last byte transfer
// bytes that end no string are taken even while a result waits on out_
// a string-ending byte waits only when the output register is full and not being taken
// rst_n is synchronous; it clears the scan state, the key and the output valid
module query_argument_finder_top
  import qaf_pkg::*;
#(
  parameter int KEY_MAX    = KEY_MAX_DEF,
  parameter int MAX_LENGTH = MAX_LENGTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata: [7:0] data_byte
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tlast,
  // in_tuser: [0] empty_string
  input  logic                   in_tuser,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // out_tdata: [0] found, [1] has_value, [17:2] value_offset, [33:18] value_length,
  // [39:34] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam logic [15:0] MAX_LEN = 16'(MAX_LENGTH);
  localparam logic [3:0]  KMAX    = 4'(KEY_MAX);

  // configuration registers
  logic [63:0] key_bytes_r;
  logic [3:0]  key_length_r;
  logic [3:0]  key_len;

  // scan state
  logic [15:0] pos_r,    pos_nxt;
  logic        match_r,  match_nxt;
  logic        inval_r,  inval_nxt;
  logic [15:0] vstart_r, vstart_nxt;
  logic [15:0] vcount_r, vcount_nxt;

  // output stage
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r,  out_data_nxt;

  logic       in_acc;
  logic       ends_string;
  logic [7:0] b;
  qaf_win_t   win;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_bytes_r  <= 64'd0;
      key_length_r <= 4'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_KEY_BYTES:  key_bytes_r  <= cfg_data;
        REG_KEY_LENGTH: key_length_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // zero length counts as one, anything above KEY_MAX as KEY_MAX
  assign key_len = (key_length_r == 4'd0) ? 4'd1 :
                   (key_length_r > KMAX)  ? KMAX : key_length_r;

  assign b           = in_tdata[7:0];
  assign ends_string = in_tlast || in_tuser;
  assign in_tready   = !out_valid_r || out_tready || !ends_string;
  assign in_acc      = in_tvalid && in_tready;

  qaf_window #(
    .KEY_MAX (KEY_MAX)
  ) u_window (
    .clk       (clk),
    .shift_en  (in_acc && !in_tuser),
    .byte_in   (b),
    .key_bytes (key_bytes_r),
    .key_len   (key_len),
    .win       (win)
  );

  always_comb begin
    logic [15:0] len16;
    logic        follow_ok;
    logic        hv;

    len16         = {12'd0, key_len};
    pos_nxt       = pos_r;
    match_nxt     = match_r;
    inval_nxt     = inval_r;
    vstart_nxt    = vstart_r;
    vcount_nxt    = vcount_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    follow_ok     = 1'b0;
    hv            = 1'b0;

    if (in_acc) begin
      if (in_tuser) begin
        // empty string: not found, and any string in progress is dropped
        out_valid_nxt = 1'b1;
        out_data_nxt  = '0;
        pos_nxt       = 16'd0;
        match_nxt     = 1'b0;
        inval_nxt     = 1'b0;
        vstart_nxt    = 16'd0;
        vcount_nxt    = 16'd0;
      end else begin
        if (match_r) begin
          if (inval_r) begin
            if (b == CH_AMP) begin
              inval_nxt = 1'b0;
            end else begin
              vcount_nxt = (vcount_r >= MAX_LEN) ? MAX_LEN : vcount_r + 16'd1;
            end
          end
        end else begin
          // name in the cells, judged by what stands before and after it
          follow_ok = (pos_r >= len16) && win.follow_hit &&
                      ((pos_r == len16) || win.amp_before || (b == CH_AMP) || (b == CH_EQ));
          if (follow_ok) begin
            match_nxt = 1'b1;
            if (b == CH_EQ) begin
              inval_nxt  = 1'b1;
              vstart_nxt = (pos_r >= MAX_LEN) ? MAX_LEN : pos_r + 16'd1;
              vcount_nxt = 16'd0;
            end
          end else if (in_tlast && (pos_r >= len16 - 16'd1) && win.end_hit) begin
            // name ending the string
            match_nxt = 1'b1;
          end
        end

        pos_nxt = (pos_r >= MAX_LEN) ? MAX_LEN : pos_r + 16'd1;

        if (in_tlast) begin
          hv            = match_nxt && (vstart_nxt != 16'd0);
          out_valid_nxt = 1'b1;
          out_data_nxt  = {6'd0,
                           hv ? vcount_nxt : 16'd0,
                           hv ? vstart_nxt : 16'd0,
                           hv, match_nxt};
          pos_nxt       = 16'd0;
          match_nxt     = 1'b0;
          inval_nxt     = 1'b0;
          vstart_nxt    = 16'd0;
          vcount_nxt    = 16'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= 16'd0;
      match_r     <= 1'b0;
      inval_r     <= 1'b0;
      vstart_r    <= 16'd0;
      vcount_r    <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      match_r     <= match_nxt;
      inval_r     <= inval_nxt;
      vstart_r    <= vstart_nxt;
      vcount_r    <= vcount_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- rtl/core/qaf_checker.sv -----
// port-level checks for the query argument finder, bound to the top level
`include "query_argument_finder_top_defines.svh"

module qaf_checker
  import qaf_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // a stalled result holds
  `QAF_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "out stalled result changed")

  // an empty string gives a not-found result on the next cycle
  `QAF_ASSERT(a_empty_result, in_tvalid && in_tready && in_tuser |=> out_tvalid && !out_tdata[0] && !out_tdata[1], "empty string result missing")

  // a value is only reported for a found name, never at offset zero
  `QAF_ASSERT(a_value_found, out_tvalid && out_tdata[1] |-> out_tdata[0] && (out_tdata[17:2] != 16'd0), "value without match")

  // reset empties the output register
  `QAF_ASSERT_ALWAYS(a_reset_clear, !rst_n |=> !out_tvalid, "out valid after reset")

endmodule

bind query_argument_finder_top qaf_checker u_qaf_checker (.*);

// ----- dv/tb_top.sv -----
// self-checking testbench for the query argument finder: directed table, then random strings
`timescale 1ns / 100ps

module tb_top;
  import qaf_pkg::*;

  localparam int unsigned MAX_LEN = 65535;
  localparam int unsigned WIN_LEN = 10;

  // one result of a query string as seen on out_tdata
  typedef struct packed {
    logic [15:0] vlen;
    logic [15:0] voff;
    logic        has_value;
    logic        found;
  } arg_hit_t;

  // rows of the directed table
  typedef enum logic [1:0] {ROW_BYTE, ROW_EMPTY, ROW_KEY, ROW_LEN} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [63:0] data;
    logic        last;
    bit          typed;
    arg_hit_t    hit;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [7:0]  in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        in_tuser = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] out_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = REG_KEY_BYTES;
  logic [63:0] cfg_data = '0;

  // typed expectation travelling with the byte on the bus
  bit          cur_typed = 1'b0;
  arg_hit_t    cur_hit = '0;

  int          in_idle_pct = 12;
  int          out_idle_pct = 51;
  int          err_cnt = 0;
  int unsigned byte_cnt = 0;

  arg_hit_t    pending_hits[$];
  dir_row_t    dir_tab[$];

  // scanner copy: key registers and per-string state
  logic [63:0] key_reg;
  logic [3:0]  klen_reg;
  logic [7:0]  win_q[WIN_LEN];
  int unsigned str_pos;
  bit          name_hit;
  bit          in_value;
  int unsigned val_start;
  int unsigned val_cnt;

  query_argument_finder_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------- scanner

  function automatic int unsigned bump(int unsigned v);
    return (v >= MAX_LEN) ? MAX_LEN : v + 1;
  endfunction

  function automatic logic [7:0] to_lower(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

  // key length register as the scanner uses it: zero counts as one, capped at eight
  function automatic int unsigned key_span();
    if (klen_reg == 4'd0) return 1;
    if (klen_reg > 4'd8) return 8;
    return klen_reg;
  endfunction

  // whole name matches with its first byte at window slot top
  function automatic bit name_fits(int unsigned top, int unsigned len);
    for (int unsigned j = 0; j < len; j++) begin
      if (to_lower(win_q[top - j]) != to_lower(key_reg[8*j +: 8])) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void clear_scan();
    foreach (win_q[k]) win_q[k] = 8'h00;
    str_pos   = 0;
    name_hit  = 1'b0;
    in_value  = 1'b0;
    val_start = 0;
    val_cnt   = 0;
  endfunction

  // one byte transfer through the scanner; returns 1 when the string ends
  function automatic bit scan_byte(input logic [7:0] b, input logic last, input logic empty,
                                   output arg_hit_t hit);
    int unsigned i;
    int unsigned len;
    bit          ok;
    i   = str_pos;
    hit = '0;
    if (empty) begin
      clear_scan();
      return 1'b1;
    end
    for (int k = WIN_LEN - 1; k > 0; k--) win_q[k] = win_q[k-1];
    win_q[0] = b;
    if (name_hit) begin
      if (in_value) begin
        if (b == CH_AMP) begin
          in_value = 1'b0;
        end else begin
          val_cnt = bump(val_cnt);
        end
      end
    end else begin
      len = key_span();
      // name just completed, current byte is its follower
      if (i >= len && name_fits(len, len)) begin
        ok = (i == len) || (win_q[len+1] == CH_AMP) || (b == CH_AMP) || (b == CH_EQ);
        if (ok) begin
          name_hit = 1'b1;
          if (b == CH_EQ) begin
            in_value  = 1'b1;
            val_start = bump(i);
            val_cnt   = 0;
          end
        end
      end
      // name ending on the last byte of the string
      if (!name_hit && last && i + 1 >= len && name_fits(len - 1, len)) name_hit = 1'b1;
    end
    str_pos = bump(i);
    if (last) begin
      hit.found = name_hit;
      if (name_hit && val_start != 0) begin
        hit.has_value = 1'b1;
        hit.voff      = val_start[15:0];
        hit.vlen      = val_cnt[15:0];
      end
      clear_scan();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------- monitor

  task automatic chk_field(string name, int unsigned e, int unsigned a);
    if (e != a) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
      err_cnt++;
    end
  endtask

  // all sampling at the rising edge, before the driver's updates land
  always @(posedge clk) begin
    arg_hit_t hit;
    arg_hit_t want;
    if (!rst_n) begin
      key_reg  <= '0;
      klen_reg <= 4'd1;
      clear_scan();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_KEY_BYTES) key_reg = cfg_data;
        else klen_reg = cfg_data[3:0];
      end
      if (in_tvalid && in_tready) begin
        if (scan_byte(in_tdata, in_tlast, in_tuser, hit))
          pending_hits.push_back(cur_typed ? cur_hit : hit);
      end
      if (out_tvalid && out_tready) begin
        if (pending_hits.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0h", $time, out_tdata);
          err_cnt++;
        end else begin
          want = pending_hits.pop_front();
          chk_field("found", want.found, out_tdata[0]);
          chk_field("has_value", want.has_value, out_tdata[1]);
          chk_field("value_offset", want.voff, out_tdata[17:2]);
          chk_field("value_length", want.vlen, out_tdata[33:18]);
          chk_field("padding", 0, out_tdata[39:34]);
        end
      end
    end
  end

  // receiver stalls at the rate of the current phase
  always @(posedge clk) out_tready <= ($urandom_range(0, 99) >= out_idle_pct);

  // ---------------------------------------------------------------- driver

  task automatic send_item(logic [7:0] b, logic last, logic empty, bit typed = 1'b0,
                           arg_hit_t hit = '0);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    in_tuser  <= empty;
    cur_typed <= typed;
    cur_hit   <= hit;
    do @(posedge clk); while (!in_tready);
    byte_cnt++;
  endtask

  // drain every result, let the block settle, then write one register
  task automatic write_reg(logic idx, logic [63:0] val);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic dir_row_t mk_row(row_kind_t kind, logic [63:0] data, logic last = 1'b0,
                                      bit typed = 1'b0, arg_hit_t hit = '0);
    dir_row_t r;
    r.kind  = kind;
    r.data  = data;
    r.last  = last;
    r.typed = typed;
    r.hit   = hit;
    return r;
  endfunction

  function automatic logic [7:0] flip_case(logic [7:0] c);
    if (((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) && $urandom_range(0, 1))
      return c ^ 8'h20;
    return c;
  endfunction

  function automatic logic [7:0] rand_letter();
    return flip_case(8'h61 + 8'($urandom_range(0, 25)));
  endfunction

  // random key and length for the next phase, extremes included
  task automatic pick_key();
    logic [63:0] kb;
    logic [3:0]  lc;
    for (int j = 0; j < 8; j++)
      kb[8*j +: 8] = ($urandom_range(0, 9) < 7) ? rand_letter() : 8'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0: kb = '1;
      1: kb = '0;
      default: ;
    endcase
    case ($urandom_range(0, 9))
      0:       lc = 4'd0;
      1:       lc = 4'($urandom_range(9, 15));
      2:       lc = 4'd8;
      3:       lc = 4'd1;
      default: lc = 4'($urandom_range(1, 8));
    endcase
    write_reg(REG_KEY_BYTES, kb);
    write_reg(REG_KEY_LENGTH, {60'h0, lc});
  endtask

  // one query string: mostly name=value pairs around the key, some noise and drops
  task automatic send_query();
    logic [7:0]  q[$];
    int unsigned len;
    int          pick;
    int          n;
    int          cut;
    len  = key_span();
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
      return;
    end
    if (pick < 18) begin
      n = $urandom_range(1, 12);
      for (int k = 0; k < n; k++) begin
        case ($urandom_range(0, 3))
          0:       q.push_back(CH_AMP);
          1:       q.push_back(CH_EQ);
          2:       q.push_back(key_reg[8*$urandom_range(0, len - 1) +: 8]);
          default: q.push_back(8'($urandom_range(0, 255)));
        endcase
      end
    end else begin
      if ($urandom_range(0, 9) == 0) q.push_back(CH_AMP);
      n = $urandom_range(1, 4);
      for (int p = 0; p < n; p++) begin
        if (p > 0) q.push_back(CH_AMP);
        case ($urandom_range(0, 9))
          0, 1, 2, 3: for (int j = 0; j < len; j++) q.push_back(flip_case(key_reg[8*j +: 8]));
          4: begin
            cut = $urandom_range(0, len - 1);
            for (int j = 0; j < len; j++)
              q.push_back(key_reg[8*j +: 8] ^ ((j == cut) ? 8'h01 : 8'h00));
          end
          5: for (int j = 0; j + 1 < len; j++) q.push_back(key_reg[8*j +: 8]);
          6: begin
            q.push_back(rand_letter());
            for (int j = 0; j < len; j++) q.push_back(key_reg[8*j +: 8]);
          end
          7: begin
            for (int j = 0; j < len; j++) q.push_back(key_reg[8*j +: 8]);
            q.push_back(rand_letter());
          end
          default: repeat ($urandom_range(1, 5)) q.push_back(rand_letter());
        endcase
        if ($urandom_range(0, 2) != 0) begin
          q.push_back(CH_EQ);
          repeat ($urandom_range(0, 5)) begin
            case ($urandom_range(0, 9))
              0:       q.push_back(CH_EQ);
              1:       q.push_back(8'($urandom_range(0, 255)));
              2:       q.push_back(8'h30 + 8'($urandom_range(0, 9)));
              default: q.push_back(rand_letter());
            endcase
          end
        end
      end
      if ($urandom_range(0, 9) == 0) q.push_back(CH_AMP);
    end
    if (q.size() == 0) q.push_back(rand_letter());
    // broken string: part of it, then dropped by an empty marker
    if ($urandom_range(0, 99) < 8) begin
      cut = $urandom_range(0, q.size() - 1);
      for (int k = 0; k < cut; k++) send_item(q[k], 1'b0, 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
      return;
    end
    foreach (q[k]) send_item(q[k], k == q.size() - 1, 1'b0);
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    int unsigned goal;
    // reset key is a single zero byte
    dir_tab.push_back(mk_row(ROW_EMPTY, 8'hA5, 1'b0, 1'b1, '0));
    dir_tab.push_back(mk_row(ROW_EMPTY, 8'h5A, 1'b1, 1'b1, '0));
    dir_tab.push_back(mk_row(ROW_BYTE, 8'h00, 1'b1, 1'b1, '{found: 1'b1, default: '0}));
    dir_tab.push_back(mk_row(ROW_BYTE, 8'hFF, 1'b1, 1'b1, '0));
    // key "aB", mixed case on the wire
    dir_tab.push_back(mk_row(ROW_KEY, 64'h4261));
    dir_tab.push_back(mk_row(ROW_LEN, 64'd2));
    // equals sign as the final byte: empty value at the string end
    dir_tab.push_back(mk_row(ROW_BYTE, "A"));
    dir_tab.push_back(mk_row(ROW_BYTE, "b"));
    dir_tab.push_back(mk_row(ROW_BYTE, "=", 1'b1, 1'b1,
                             '{found: 1'b1, has_value: 1'b1, voff: 16'd3, vlen: 16'd0}));
    dir_tab.push_back(mk_row(ROW_BYTE, "a"));
    dir_tab.push_back(mk_row(ROW_BYTE, "b"));
    dir_tab.push_back(mk_row(ROW_BYTE, "="));
    dir_tab.push_back(mk_row(ROW_BYTE, "q"));
    dir_tab.push_back(mk_row(ROW_BYTE, "&", 1'b1));
    // empty marker drops the string in progress
    dir_tab.push_back(mk_row(ROW_BYTE, "a"));
    dir_tab.push_back(mk_row(ROW_EMPTY, 8'h00, 1'b0, 1'b1, '0));
    dir_tab.push_back(mk_row(ROW_BYTE, "b", 1'b1));
    // length zero behaves as one; key is the ampersand itself
    dir_tab.push_back(mk_row(ROW_LEN, 64'd0));
    dir_tab.push_back(mk_row(ROW_KEY, 64'h26));
    dir_tab.push_back(mk_row(ROW_BYTE, 8'h26, 1'b1));
    // length above eight is capped; all-ones key, every byte compared
    dir_tab.push_back(mk_row(ROW_KEY, '1));
    dir_tab.push_back(mk_row(ROW_LEN, 64'd15));
    for (int k = 0; k < 8; k++) dir_tab.push_back(mk_row(ROW_BYTE, 8'hFF, k == 7));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[r]) begin
      case (dir_tab[r].kind)
        ROW_BYTE:  send_item(dir_tab[r].data[7:0], dir_tab[r].last, 1'b0, dir_tab[r].typed,
                             dir_tab[r].hit);
        ROW_EMPTY: send_item(dir_tab[r].data[7:0], dir_tab[r].last, 1'b1, dir_tab[r].typed,
                             dir_tab[r].hit);
        ROW_KEY:   write_reg(REG_KEY_BYTES, dir_tab[r].data);
        ROW_LEN:   write_reg(REG_KEY_LENGTH, dir_tab[r].data);
        default: ;
      endcase
    end

    // random strings: sender light, receiver heavy; then swapped; then free running
    for (int m = 0; m < 3; m++) begin
      in_idle_pct  = (m == 0) ? 12 : (m == 1) ? 51 : 0;
      out_idle_pct = (m == 0) ? 51 : (m == 1) ? 12 : 0;
      for (int s = 0; s < 5; s++) begin
        pick_key();
        goal = byte_cnt + 107;
        while (byte_cnt < goal) send_query();
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_cnt == 0 && pending_hits.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog well beyond the slowest legal run
  initial begin
    #8_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
